// ----- hdl/png_row_unfilter_core_defines.svh -----
// ----------------------------------------------------------------------------
// png_row_unfilter_core_defines
// assertion macros for the png row unfilter core, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PNG_ROW_UNFILTER_CORE_DEFINES_SVH
`define PNG_ROW_UNFILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PRU_ASSERT_IMP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PRU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRU_ASSERT_IMP(label, prop, msg)
`define PRU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// pru_pkg
// shared constants, codes and types of the png row unfilter core
// ----------------------------------------------------------------------------
package pru_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;

    localparam int WEFF_W = (POS_W > CFG_WIDTH_W) ? POS_W : CFG_WIDTH_W;
    localparam int ROW_W  = WEFF_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DEPTH = 2;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_FILTER,
        KIND_DATA,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] x;
        logic [7:0]        raw;
        logic [2:0]        filt;
        logic              first_row;
        logic              ch4;
        logic [1:0]        chan;
        logic              emit;
        logic              row_end;
        logic              img_end;
    } t_entry;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_row;
        logic       last_of_image;
        logic       bad_filter;
    } t_pixel;

endpackage

// ----- hdl/pru_front.sv -----
// ----------------------------------------------------------------------------
// pru_front
// byte classifier: configuration, row and image position, filter type decode
// ----------------------------------------------------------------------------
module pru_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic [7:0]                      i_raw_byte,
    output logic                            o_entry_valid,
    output pru_pkg::t_entry                 o_entry
);
    import pru_pkg::*;

    logic [CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height;
    logic                    r_cfg_alpha;

    logic [POS_W-1:0]        r_pos, n_pos;
    logic [1:0]              r_mod3, n_mod3;
    logic [CFG_HEIGHT_W-1:0] r_row, n_row;
    logic                    r_first, n_first;
    logic                    r_skip, n_skip;
    logic [2:0]              r_filt, n_filt;

    logic [WEFF_W-1:0]       w_ext;
    logic [WEFF_W-1:0]       w_eff;
    logic [ROW_W-1:0]        row_len;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [ADDR_W-1:0]       x;
    logic [1:0]              chan;
    logic [1:0]              last_chan;
    logic                    is_filter;
    logic                    bad_code;
    logic                    row_end;
    logic                    img_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_W'(1);
            r_cfg_height <= CFG_HEIGHT_W'(1);
            r_cfg_alpha  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                CFG_HAS_ALPHA:    r_cfg_alpha  <= i_cfg_data[0];
                default:          r_cfg_alpha  <= r_cfg_alpha;
            endcase
        end
    end

    always_comb begin
        w_ext = WEFF_W'(r_cfg_width);
        if (w_ext == '0) begin
            w_eff = WEFF_W'(1);
        end else if (w_ext > WEFF_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_cfg_alpha) begin
            row_len = ROW_W'(w_eff) << 2;
        end else begin
            row_len = (ROW_W'(w_eff) << 1) + ROW_W'(w_eff);
        end
        h_eff     = (r_cfg_height == '0) ? CFG_HEIGHT_W'(1) : r_cfg_height;
        x         = ADDR_W'(r_pos - POS_W'(1));
        chan      = r_cfg_alpha ? x[1:0] : r_mod3;
        last_chan = r_cfg_alpha ? 2'd3 : 2'd2;
        is_filter = (r_pos == '0);
        bad_code  = (i_raw_byte > 8'(FILT_PAETH));
        row_end   = (ROW_W'(r_pos) >= row_len);
        img_end   = (({1'b0, r_row} + 17'd1) >= {1'b0, h_eff});
    end

    // entry for the back end
    always_comb begin
        o_entry_valid     = !r_skip;
        o_entry.kind      = is_filter ? (bad_code ? KIND_BAD : KIND_FILTER) : KIND_DATA;
        o_entry.x         = x;
        o_entry.raw       = i_raw_byte;
        o_entry.filt      = r_filt;
        o_entry.first_row = r_first;
        o_entry.ch4       = r_cfg_alpha;
        o_entry.chan      = chan;
        o_entry.emit      = (chan == last_chan);
        o_entry.row_end   = row_end;
        o_entry.img_end   = img_end;
    end

    always_comb begin
        n_pos   = r_pos;
        n_mod3  = r_mod3;
        n_row   = r_row;
        n_first = r_first;
        n_skip  = r_skip;
        n_filt  = r_filt;
        if (i_accept) begin
            if (is_filter) begin
                n_pos  = POS_W'(1);
                n_mod3 = 2'd0;
                if (!r_skip) begin
                    if (bad_code) begin
                        n_skip = 1'b1;
                    end else begin
                        n_filt = i_raw_byte[2:0];
                    end
                end
            end else begin
                n_pos  = r_pos + POS_W'(1);
                n_mod3 = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                if (row_end) begin
                    n_pos = '0;
                    if (img_end) begin
                        n_row   = '0;
                        n_first = 1'b1;
                        n_skip  = 1'b0;
                    end else begin
                        n_row   = r_row + CFG_HEIGHT_W'(1);
                        n_first = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mod3  <= 2'd0;
            r_row   <= '0;
            r_first <= 1'b1;
            r_skip  <= 1'b0;
            r_filt  <= FILT_NONE;
        end else begin
            r_pos   <= n_pos;
            r_mod3  <= n_mod3;
            r_row   <= n_row;
            r_first <= n_first;
            r_skip  <= n_skip;
            r_filt  <= n_filt;
        end
    end

endmodule

// ----- hdl/pru_queue.sv -----
// ----------------------------------------------------------------------------
// pru_queue
// short entry queue between the classifier and the reconstruction back end
// ----------------------------------------------------------------------------
module pru_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pru_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pru_pkg::t_entry o_entry
);
    import pru_pkg::*;

    t_entry             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    always_comb begin
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_entry = r_slot[r_rd_ptr];
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/pru_back.sv -----
// ----------------------------------------------------------------------------
// pru_back
// reconstruction back end: row store, predictors, pixel assembly, result queue
// ----------------------------------------------------------------------------
module pru_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  pru_pkg::t_entry i_head,
    output logic            o_head_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output pru_pkg::t_pixel o_pixel
);
    import pru_pkg::*;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        pa = (b > c) ? 10'(b - c) : 10'(c - b);
        pb = (a > c) ? 10'(a - c) : 10'(c - a);
        ab = 10'(a) + 10'(b);
        cc = 10'(c) + 10'(c);
        pc = (ab > cc) ? ab - cc : cc - ab;
        if (pa <= pb && pa <= pc) begin
            paeth_pick = a;
        end else if (pb <= pc) begin
            paeth_pick = b;
        end else begin
            paeth_pick = c;
        end
    endfunction

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rdata;
    logic              r_s1_valid;
    t_entry            r_s1;
    logic [31:0]       r_left;
    logic [31:0]       r_upleft;
    logic [23:0]       r_hold, n_hold;

    t_pixel            r_out [OUT_DEPTH];
    logic [OPTR_W-1:0] r_out_wr;
    logic [OPTR_W-1:0] r_out_rd;
    logic [OCNT_W-1:0] r_out_cnt, n_out_cnt;

    logic       out_room;
    logic       produces;
    logic       commit;
    logic       advance;
    logic       out_push;
    logic       out_pop;
    logic       is_data;
    logic [7:0] a_byte;
    logic [7:0] b_byte;
    logic [7:0] c_byte;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] v_byte;
    t_pixel     result;

    always_comb begin
        is_data    = (r_s1.kind == KIND_DATA);
        out_room   = (r_out_cnt != OCNT_W'(OUT_DEPTH));
        produces   = (r_s1.kind == KIND_BAD) || (is_data && r_s1.emit);
        commit     = r_s1_valid && (!produces || out_room);
        advance    = !r_s1_valid || commit;
        o_head_pop = advance && i_head_valid;
        out_push   = commit && produces;
        out_pop    = i_pop && !o_empty;
    end

    // predictors
    always_comb begin
        a_byte  = r_s1.ch4 ? r_left[31:24] : r_left[23:16];
        c_byte  = r_s1.ch4 ? r_upleft[31:24] : r_upleft[23:16];
        b_byte  = r_s1.first_row ? 8'd0 : r_rdata;
        avg_sum = 9'(a_byte) + 9'(b_byte);
        case (r_s1.filt)
            FILT_SUB:   pred = a_byte;
            FILT_UP:    pred = b_byte;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pick(a_byte, b_byte, c_byte);
            default:    pred = 8'd0;
        endcase
        v_byte = r_s1.raw + pred;
        case (r_s1.chan)
            2'd0:    n_hold = {r_hold[23:8], v_byte};
            2'd1:    n_hold = {r_hold[23:16], v_byte, r_hold[7:0]};
            2'd2:    n_hold = {v_byte, r_hold[15:0]};
            default: n_hold = r_hold;
        endcase
        if (r_s1.kind == KIND_BAD) begin
            result = '0;
            result.bad_filter = 1'b1;
        end else begin
            result.red           = n_hold[7:0];
            result.green         = n_hold[15:8];
            result.blue          = n_hold[23:16];
            result.last_of_row   = r_s1.row_end;
            result.last_of_image = r_s1.row_end && r_s1.img_end;
            result.bad_filter    = 1'b0;
        end
    end

    // row store, registered read at pop, write at commit
    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            r_rdata <= r_mem[i_head.x];
        end
        if (commit && is_data) begin
            r_mem[r_s1.x] <= v_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            r_s1 <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
            r_upleft   <= '0;
            r_hold     <= '0;
        end else begin
            if (advance) begin
                r_s1_valid <= i_head_valid;
            end
            if (commit) begin
                if (is_data) begin
                    r_left   <= {r_left[23:0], v_byte};
                    r_upleft <= {r_upleft[23:0], b_byte};
                    r_hold   <= n_hold;
                end else begin
                    r_left   <= '0;
                    r_upleft <= '0;
                end
            end
        end
    end

    // result queue
    always_comb begin
        o_empty   = (r_out_cnt == '0);
        o_pixel   = r_out[r_out_rd];
        n_out_cnt = r_out_cnt;
        if (out_push && !out_pop) begin
            n_out_cnt = r_out_cnt + OCNT_W'(1);
        end else if (!out_push && out_pop) begin
            n_out_cnt = r_out_cnt - OCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out[r_out_wr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (out_push) begin
                r_out_wr <= r_out_wr + OPTR_W'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + OPTR_W'(1);
            end
            r_out_cnt <= n_out_cnt;
        end
    end

endmodule

// ----- hdl/png_row_unfilter_core.sv -----
// ----------------------------------------------------------------------------
// png_row_unfilter_core
// Rebuilds PNG scanlines (filter types none, sub, up, average, Paeth) from the
// inflated byte stream and hands out one RGB pixel per three or four bytes,
// alpha dropped. One byte beat is taken per cycle while the queue is not full:
// a front end decodes the filter byte and tracks row and image position, a
// four-entry queue feeds the back end, and the back end reads the 4096 x 8
// previous-row store once and writes it once per byte. A pixel's last byte
// passes the queue and the back-end stage register; a two-entry result queue
// absorbs pop stalls. The row store needs no clearing after reset since the
// first row of an image ignores what it reads. A filter type above 4 gives one
// bad_filter beat with zero colors and the rest of that image is dropped. Size
// and alpha registers take effect on the next byte beat.
// ----------------------------------------------------------------------------
`include "png_row_unfilter_core_defines.svh"

module png_row_unfilter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_raw_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic                            o_last_of_row,
    output logic                            o_last_of_image,
    output logic                            o_bad_filter
);
    import pru_pkg::*;

    logic   accept;
    logic   entry_valid;
    t_entry front_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_entry q_head;
    t_pixel pixel;

    assign accept = push && !full;
    assign q_push = accept && entry_valid;

    pru_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_raw_byte    (i_raw_byte),
        .o_entry_valid (entry_valid),
        .o_entry       (front_entry)
    );

    pru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_head)
    );

    pru_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_head_pop   (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel      (pixel)
    );

    assign o_red           = pixel.red;
    assign o_green         = pixel.green;
    assign o_blue          = pixel.blue;
    assign o_last_of_row   = pixel.last_of_row;
    assign o_last_of_image = pixel.last_of_image;
    assign o_bad_filter    = pixel.bad_filter;

    `PRU_ASSERT_IMP(a_bad_is_blank, (!empty && o_bad_filter) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && !o_last_of_row && !o_last_of_image), "bad filter beat carries pixel data")
    `PRU_ASSERT_IMP(a_image_ends_row, (!empty && o_last_of_image) |-> o_last_of_row, "image end without row end")
    `PRU_ASSERT_NXT(a_full_holds, full && !q_pop, full, "queue drained without a pop")

endmodule
